// ----- rtl/hash_displace_table_builder_unit_assert.svh -----
// assertion helpers used by hdtb_dp
`ifndef HASH_DISPLACE_TABLE_BUILDER_UNIT_ASSERT_SVH
`define HASH_DISPLACE_TABLE_BUILDER_UNIT_ASSERT_SVH

// same-cycle implication
`define HDTB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HDTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hdtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtb_pkg
// shared types and constants of the hash and displace table builder
// ----------------------------------------------------------------------------
package hdtb_pkg;

	localparam int HASH_W     = 32;
	localparam int PORT_W     = 16;
	localparam int IDX_W      = 12;
	localparam int DISP_W     = 11;
	localparam int LOG2_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int HASH_SHIFT = 10;
	localparam int PROD_SHIFT = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOG2   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_LIMIT  = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD      = 2'd0,
		CMD_BUILD     = 2'd1,
		CMD_READ_DISP = 2'd2,
		CMD_READ_BKT  = 2'd3
	} command_t;

	typedef enum logic [2:0] {
		STAT_LOADED     = 3'd0,
		STAT_FULL       = 3'd1,
		STAT_BUILD_OK   = 3'd2,
		STAT_BUILD_FAIL = 3'd3,
		STAT_READ       = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_RST_CLR, S_IDLE, S_RD, S_CLR,
		S_CNT_A, S_CNT_B, S_CNT_C,
		S_PRE_A, S_PRE_B,
		S_SCT_A, S_SCT_B, S_SCT_C,
		S_SCAN, S_SCAN_END, S_PICK,
		S_PL_ST, S_PL_D,
		S_P_J, S_P_M, S_P_B, S_P_C,
		S_RB_A, S_RB_B,
		S_OK, S_FAIL
	} fsm_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic rd_issue;
		logic rd_res;
		logic clr_start;
		logic clr;
		logic cnt_c;
		logic pre_a;
		logic pre_b;
		logic sct_c;
		logic scan_init;
		logic scan;
		logic pl_d;
		logic place_ok;
		logic p_m;
		logic p_b;
		logic p_c;
		logic rb_a;
		logic rb_b;
		logic res_ok;
		logic res_fail;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic clr_last;
		logic items_done;
		logic slot_last;
		logic best_zero;
		logic lim_small;
		logic j_done;
		logic p_hit;
		logic logged_zero;
		logic d_last;
	} stat_t;

endpackage

// ----- rtl/hdtb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtb_req_if
// request channel: command with load and read payload
// ----------------------------------------------------------------------------
interface hdtb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] key_hash;
	logic [15:0] port;
	logic [11:0] read_index;

	modport source (output valid, command, key_hash, port, read_index, input ready);
	modport sink (input valid, command, key_hash, port, read_index, output ready);
endinterface

// ----- rtl/hdtb_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtb_rsp_if
// response channel: status and read value
// ----------------------------------------------------------------------------
interface hdtb_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] read_value;

	modport source (output valid, status, read_value, input ready);
	modport sink (input valid, status, read_value, output ready);
endinterface

// ----- rtl/hdtb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtb_ctrl
// sequencer for load, read and the table build passes
// ----------------------------------------------------------------------------
module hdtb_ctrl import hdtb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_command,
	input  stat_t      stat,
	output logic       req_ready,
	output cmd_t       cmd
);

	fsm_state_t state_q, state_nx;
	logic       acc;

	assign req_ready = (state_q == S_IDLE) && stat.out_free;
	assign acc       = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_RST_CLR: if (stat.clr_last) state_nx = S_IDLE;
			S_IDLE: begin
				if (acc) begin
					case (command_t'(req_command))
						CMD_LOAD:  state_nx = S_IDLE;
						CMD_BUILD: state_nx = S_CLR;
						default:   state_nx = S_RD;
					endcase
				end
			end
			S_RD:     state_nx = S_IDLE;
			S_CLR:    if (stat.clr_last) state_nx = S_CNT_A;
			S_CNT_A:  state_nx = stat.items_done ? S_PRE_A : S_CNT_B;
			S_CNT_B:  state_nx = S_CNT_C;
			S_CNT_C:  state_nx = S_CNT_A;
			S_PRE_A:  state_nx = S_PRE_B;
			S_PRE_B:  state_nx = stat.slot_last ? S_SCT_A : S_PRE_A;
			S_SCT_A:  state_nx = stat.items_done ? S_SCAN : S_SCT_B;
			S_SCT_B:  state_nx = S_SCT_C;
			S_SCT_C:  state_nx = S_SCT_A;
			S_SCAN:   if (stat.slot_last) state_nx = S_SCAN_END;
			S_SCAN_END: state_nx = S_PICK;
			S_PICK:   state_nx = stat.best_zero ? S_OK : S_PL_ST;
			S_PL_ST:  state_nx = S_PL_D;
			S_PL_D:   state_nx = stat.lim_small ? S_FAIL : S_P_J;
			S_P_J:    state_nx = stat.j_done ? S_SCAN : S_P_M;
			S_P_M:    state_nx = S_P_B;
			S_P_B:    state_nx = S_P_C;
			S_P_C:    state_nx = stat.p_hit ? S_P_J : S_RB_A;
			S_RB_A: begin
				if (!stat.logged_zero) begin
					state_nx = S_RB_B;
				end else begin
					state_nx = stat.d_last ? S_FAIL : S_P_J;
				end
			end
			S_RB_B:   state_nx = S_RB_A;
			S_OK:     state_nx = S_IDLE;
			S_FAIL:   state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_RST_CLR: cmd.clr = 1'b1;
			S_IDLE: begin
				if (acc) begin
					case (command_t'(req_command))
						CMD_LOAD:  cmd.load = 1'b1;
						CMD_BUILD: cmd.clr_start = 1'b1;
						default:   cmd.rd_issue = 1'b1;
					endcase
				end
			end
			S_RD:     cmd.rd_res = 1'b1;
			S_CLR:    cmd.clr = 1'b1;
			S_CNT_C:  cmd.cnt_c = 1'b1;
			S_PRE_A:  cmd.pre_a = 1'b1;
			S_PRE_B:  cmd.pre_b = 1'b1;
			S_SCT_A:  cmd.scan_init = stat.items_done;
			S_SCT_C:  cmd.sct_c = 1'b1;
			S_SCAN:   cmd.scan = 1'b1;
			S_PL_D:   cmd.pl_d = 1'b1;
			S_P_J:    cmd.place_ok = stat.j_done;
			S_P_M:    cmd.p_m = 1'b1;
			S_P_B:    cmd.p_b = 1'b1;
			S_P_C:    cmd.p_c = 1'b1;
			S_RB_A:   cmd.rb_a = 1'b1;
			S_RB_B:   cmd.rb_b = 1'b1;
			S_OK:     cmd.res_ok = 1'b1;
			S_FAIL:   cmd.res_fail = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

// ----- rtl/hdtb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdtb_dp
// item stores, grouping tables, bucket table, counters and result register
// ----------------------------------------------------------------------------
`include "hash_displace_table_builder_unit_assert.svh"

module hdtb_dp import hdtb_pkg::*; #(
	parameter int MAX_ITEMS   = 1024,
	parameter int SLOT_BITS   = 8,
	parameter int BUCKET_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output stat_t                stat,
	input  logic [1:0]           req_command,
	input  logic [HASH_W-1:0]    req_key_hash,
	input  logic [PORT_W-1:0]    req_port,
	input  logic [IDX_W-1:0]     req_read_index,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DISP_W-1:0]    cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [2:0]           rsp_status,
	output logic [PORT_W-1:0]    rsp_read_value
);

	localparam int IW = $clog2(MAX_ITEMS + 1);
	localparam int IA = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int NS = 1 << SLOT_BITS;
	localparam int NB = 1 << BUCKET_BITS;
	localparam int CB = (BUCKET_BITS > SLOT_BITS) ? BUCKET_BITS : SLOT_BITS;

	// configuration
	logic [LOG2_W-1:0] sl_q, bl_q;
	logic [DISP_W-1:0] lim_q;

	// stores
	logic [HASH_W-1:0]      item_h_mem [MAX_ITEMS];
	logic [PORT_W-1:0]      item_p_mem [MAX_ITEMS];
	logic [IW-1:0]          cnt_mem    [NS];
	logic [IW-1:0]          start_mem  [NS];
	logic [IW-1:0]          cur_mem    [NS];
	logic [HASH_W-1:0]      grp_h_mem  [MAX_ITEMS];
	logic [PORT_W-1:0]      grp_p_mem  [MAX_ITEMS];
	logic [DISP_W-1:0]      disp_mem   [NS];
	logic [PORT_W-1:0]      bkt_mem    [NB];
	logic [BUCKET_BITS-1:0] log_mem    [MAX_ITEMS];

	logic [HASH_W-1:0]      item_h_rd, grp_h_rd;
	logic [PORT_W-1:0]      item_p_rd, grp_p_rd, bkt_rd;
	logic [IW-1:0]          cnt_rd, start_rd, cur_rd;
	logic [DISP_W-1:0]      disp_rd;
	logic [BUCKET_BITS-1:0] log_rd;

	// counters and working registers
	logic [IW-1:0]          item_cnt_q, i_q, acc_q, j_q, logged_q, best_cnt_q, base_q;
	logic [SLOT_BITS-1:0]   s_q, slot_q, slot_s1, best_slot_q;
	logic                   v_s1;
	logic [CB-1:0]          clr_q;
	logic [DISP_W-1:0]      d_q;
	logic [NS-1:0]          done_q;
	logic [HASH_W-1:0]      h_q, prod_s1;
	logic [PORT_W-1:0]      p_q, p_s1, p_s2;
	logic [BUCKET_BITS-1:0] b_s2;
	logic [1:0]             rd_cmd_q;
	logic                   rd_ok_q;
	logic                   out_valid_q;
	logic [2:0]             out_status_q;
	logic [PORT_W-1:0]      out_value_q;

	// effective masks
	logic [4:0]             sl_eff, bl_eff;
	logic [SLOT_BITS-1:0]   smask, item_slot, clr_slot;
	logic [BUCKET_BITS-1:0] bmask, b_calc, bkt_raddr, bkt_waddr, clr_bkt;
	logic [PORT_W-1:0]      bkt_wdata;
	logic                   bkt_we, clr_bkt_ok, clr_slot_ok, rd_in_range;
	logic [SLOT_BITS-1:0]   cnt_raddr;
	logic [IA-1:0]          grp_raddr;

	assign sl_eff = (32'(sl_q) > SLOT_BITS) ? 5'(SLOT_BITS) : 5'(sl_q);
	assign bl_eff = (32'(bl_q) > BUCKET_BITS) ? 5'(BUCKET_BITS) : 5'(bl_q);
	assign smask  = SLOT_BITS'((32'd1 << sl_eff) - 32'd1);
	assign bmask  = BUCKET_BITS'((32'd1 << bl_eff) - 32'd1);

	assign item_slot   = SLOT_BITS'(item_h_rd) & smask;
	assign b_calc      = BUCKET_BITS'(prod_s1 >> PROD_SHIFT) & bmask;
	assign clr_bkt     = BUCKET_BITS'(clr_q);
	assign clr_slot    = SLOT_BITS'(clr_q);
	assign clr_bkt_ok  = (32'(clr_q) >> BUCKET_BITS) == 32'd0;
	assign clr_slot_ok = (32'(clr_q) >> SLOT_BITS) == 32'd0;
	assign grp_raddr   = IA'(base_q + j_q);

	always_comb begin
		if (command_t'(req_command) == CMD_READ_DISP) begin
			rd_in_range = (32'(req_read_index) >> SLOT_BITS) == 32'd0;
		end else begin
			rd_in_range = (32'(req_read_index) >> BUCKET_BITS) == 32'd0;
		end
	end

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sl_q  <= LOG2_W'(8);
			bl_q  <= LOG2_W'(12);
			lim_q <= DISP_W'(2047);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOT_LOG2:   sl_q  <= cfg_data[LOG2_W-1:0];
				REG_BUCKET_LOG2: bl_q  <= cfg_data[LOG2_W-1:0];
				REG_DISP_LIMIT:  lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item store
	always_ff @(posedge clk) begin
		if (cmd.load && (32'(item_cnt_q) < MAX_ITEMS)) begin
			item_h_mem[IA'(item_cnt_q)] <= req_key_hash;
			item_p_mem[IA'(item_cnt_q)] <= req_port;
		end
		item_h_rd <= item_h_mem[IA'(i_q)];
		item_p_rd <= item_p_mem[IA'(i_q)];
	end

	// slot counts
	always_comb begin
		if (cmd.scan || cmd.pre_a) begin
			cnt_raddr = s_q;
		end else begin
			cnt_raddr = item_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr && clr_slot_ok) begin
			cnt_mem[clr_slot] <= '0;
		end else if (cmd.cnt_c) begin
			cnt_mem[slot_q] <= cnt_rd + IW'(1);
		end
		// prefix and scan passes read at s_q, count pass reads at the item's slot
		cnt_rd <= cnt_mem[cnt_raddr];
	end

	// slot start and fill cursor
	always_ff @(posedge clk) begin
		if (cmd.pre_b) begin
			start_mem[s_q] <= acc_q;
		end
		start_rd <= start_mem[best_slot_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.pre_b) begin
			cur_mem[s_q] <= acc_q;
		end else if (cmd.sct_c) begin
			cur_mem[slot_q] <= cur_rd + IW'(1);
		end
		cur_rd <= cur_mem[item_slot];
	end

	// grouped items
	always_ff @(posedge clk) begin
		if (cmd.sct_c) begin
			grp_h_mem[IA'(cur_rd)] <= h_q;
			grp_p_mem[IA'(cur_rd)] <= p_q;
		end
		grp_h_rd <= grp_h_mem[grp_raddr];
		grp_p_rd <= grp_p_mem[grp_raddr];
	end

	// displacement table
	always_ff @(posedge clk) begin
		if (cmd.clr && clr_slot_ok) begin
			disp_mem[clr_slot] <= '0;
		end else if (cmd.place_ok) begin
			disp_mem[best_slot_q] <= d_q;
		end
		disp_rd <= disp_mem[SLOT_BITS'(req_read_index)];
	end

	// bucket table
	always_comb begin
		bkt_we    = 1'b0;
		bkt_waddr = b_s2;
		bkt_wdata = p_s2;
		if (cmd.clr && clr_bkt_ok) begin
			bkt_we    = 1'b1;
			bkt_waddr = clr_bkt;
			bkt_wdata = '0;
		end else if (cmd.p_c && (bkt_rd == '0)) begin
			bkt_we = 1'b1;
		end else if (cmd.rb_b) begin
			bkt_we    = 1'b1;
			bkt_waddr = log_rd;
			bkt_wdata = '0;
		end
		bkt_raddr = cmd.p_b ? b_calc : BUCKET_BITS'(req_read_index);
	end

	always_ff @(posedge clk) begin
		if (bkt_we) begin
			bkt_mem[bkt_waddr] <= bkt_wdata;
		end
		bkt_rd <= bkt_mem[bkt_raddr];
	end

	// buckets written by the current attempt
	always_ff @(posedge clk) begin
		if (cmd.p_c && (bkt_rd == '0)) begin
			log_mem[IA'(logged_q)] <= b_s2;
		end
		log_rd <= log_mem[IA'(logged_q - IW'(1))];
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q  <= '0;
			clr_q       <= '0;
			i_q         <= '0;
			s_q         <= '0;
			acc_q       <= '0;
			j_q         <= '0;
			logged_q    <= '0;
			d_q         <= DISP_W'(1);
			done_q      <= '0;
			v_s1        <= 1'b0;
			best_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.scan;
			if (cmd.load && (32'(item_cnt_q) < MAX_ITEMS)) begin
				item_cnt_q <= item_cnt_q + IW'(1);
			end
			if (cmd.clr) begin
				clr_q <= clr_q + CB'(1);
			end
			if (cmd.clr_start) begin
				done_q <= '0;
				i_q    <= '0;
				s_q    <= '0;
				acc_q  <= '0;
			end
			if (cmd.cnt_c || cmd.sct_c) begin
				i_q <= i_q + IW'(1);
			end
			if (cmd.pre_b) begin
				acc_q <= acc_q + cnt_rd;
				s_q   <= stat.slot_last ? '0 : s_q + SLOT_BITS'(1);
				if (stat.slot_last) begin
					i_q <= '0;
				end
			end
			if (cmd.scan_init || cmd.place_ok) begin
				s_q        <= '0;
				best_cnt_q <= '0;
			end
			if (cmd.place_ok) begin
				done_q[best_slot_q] <= 1'b1;
			end
			if (cmd.scan) begin
				s_q <= s_q + SLOT_BITS'(1);
			end
			// strict compare keeps the lowest slot among equal counts
			if (v_s1 && !done_q[slot_s1] && (cnt_rd > best_cnt_q)) begin
				best_cnt_q <= cnt_rd;
			end
			if (cmd.pl_d) begin
				d_q      <= DISP_W'(1);
				j_q      <= '0;
				logged_q <= '0;
			end
			if (cmd.p_c) begin
				j_q <= j_q + IW'(1);
				if (bkt_rd == '0) begin
					logged_q <= logged_q + IW'(1);
				end
			end
			if (cmd.rb_a) begin
				if (stat.logged_zero) begin
					d_q <= d_q + DISP_W'(1);
					j_q <= '0;
				end else begin
					logged_q <= logged_q - IW'(1);
				end
			end
			if (cmd.load || cmd.rd_res || cmd.res_ok || cmd.res_fail) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		slot_s1 <= s_q;
		if (v_s1 && !done_q[slot_s1] && (cnt_rd > best_cnt_q)) begin
			best_slot_q <= slot_s1;
		end
		if (cmd.pl_d) begin
			base_q <= start_rd;
		end
		if (cmd.cnt_c == 1'b0) begin
			slot_q <= item_slot;
		end
		h_q      <= item_h_rd;
		p_q      <= item_p_rd;
		// product kept modulo 2^32
		prod_s1  <= (grp_h_rd >> HASH_SHIFT) * HASH_W'(d_q);
		p_s1     <= grp_p_rd;
		b_s2     <= b_calc;
		p_s2     <= p_s1;
		if (cmd.rd_issue) begin
			rd_cmd_q <= req_command;
			rd_ok_q  <= rd_in_range;
		end
		if (cmd.load) begin
			out_status_q <= (32'(item_cnt_q) < MAX_ITEMS) ? STAT_LOADED : STAT_FULL;
			out_value_q  <= '0;
		end else if (cmd.rd_res) begin
			out_status_q <= STAT_READ;
			if (!rd_ok_q) begin
				out_value_q <= '0;
			end else if (command_t'(rd_cmd_q) == CMD_READ_DISP) begin
				out_value_q <= PORT_W'(disp_rd);
			end else begin
				out_value_q <= bkt_rd;
			end
		end else if (cmd.res_ok) begin
			out_status_q <= STAT_BUILD_OK;
			out_value_q  <= '0;
		end else if (cmd.res_fail) begin
			out_status_q <= STAT_BUILD_FAIL;
			out_value_q  <= '0;
		end
	end

	assign stat.out_free    = !out_valid_q || rsp_ready;
	assign stat.clr_last    = (clr_q == '1);
	assign stat.items_done  = (i_q == item_cnt_q);
	assign stat.slot_last   = (s_q == smask);
	assign stat.best_zero   = (best_cnt_q == '0);
	assign stat.lim_small   = (lim_q < DISP_W'(2));
	assign stat.j_done      = (j_q == best_cnt_q);
	assign stat.p_hit       = (bkt_rd == '0) || (bkt_rd == p_s2);
	assign stat.logged_zero = (logged_q == '0);
	assign stat.d_last      = ((12'(d_q) + 12'd1) >= 12'(lim_q));

	assign rsp_valid      = out_valid_q;
	assign rsp_status     = out_status_q;
	assign rsp_read_value = out_value_q;

	`HDTB_ASSERT_IMP(a_logged_le_j, clk, arst_n, 1'b1, logged_q <= j_q, "log exceeds items placed")
	`HDTB_ASSERT_IMP(a_d_nonzero, clk, arst_n, cmd.p_m, d_q != '0, "zero displacement tried")
	`HDTB_ASSERT_NXT(a_rb_pair, clk, arst_n, cmd.rb_a && !stat.logged_zero, cmd.rb_b, "rollback write skipped")
	`HDTB_ASSERT_IMP(a_items_bound, clk, arst_n, 1'b1, 32'(item_cnt_q) <= MAX_ITEMS, "item count overflow")

endmodule

// ----- rtl/hash_displace_table_builder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_displace_table_builder_unit
// loads key hashes with ports, builds a displacement and bucket table
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  request   | in  | valid / ready | command, key_hash, port, read_index
//  response  | out | valid / ready | status, read_value
//  cfg       | in  | cfg_we        | cfg_index, cfg_data
//
// load is accepted and answered without leaving S_IDLE; reads pass through S_RD since the table port is registered.
// build: a clear sweep, a counting pass over the items, an offset pass over the
// slots and a grouping pass over the items; each placed slot costs a scan of the
// active slots and a setup, and one last scan ends the build; an attempt tries
// each item of the slot in turn, a rollback clears each logged bucket.
// after reset a clearing pass runs before request is ready.
// a stalled response holds; request ready drops while the result is unread.
module hash_displace_table_builder_unit import hdtb_pkg::*; #(
	parameter int MAX_ITEMS   = 1024,
	parameter int SLOT_BITS   = 8,
	parameter int BUCKET_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hdtb_req_if.sink             request,
	hdtb_rsp_if.source           response,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DISP_W-1:0]    cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	hdtb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (request.valid),
		.req_command (request.command),
		.stat        (stat),
		.req_ready   (request.ready),
		.cmd         (cmd)
	);

	hdtb_dp #(
		.MAX_ITEMS   (MAX_ITEMS),
		.SLOT_BITS   (SLOT_BITS),
		.BUCKET_BITS (BUCKET_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_command    (request.command),
		.req_key_hash   (request.key_hash),
		.req_port       (request.port),
		.req_read_index (request.read_index),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rsp_valid      (response.valid),
		.rsp_ready      (response.ready),
		.rsp_status     (response.status),
		.rsp_read_value (response.read_value)
	);

endmodule

// ----- tb/sv/hash_displace_table_builder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_displace_table_builder_unit_tb
// loads key hashes, builds tables under several register settings and reads
// them back; every response is checked against its typed expectation or an
// in-bench table predictor
module hash_displace_table_builder_unit_tb;
	import hdtb_pkg::*;

	localparam int STORE_DEPTH  = 1024;
	localparam int SLOT_MAX     = 8;
	localparam int BUCKET_MAX   = 12;
	localparam int STALL_LIMIT  = 2000000;
	localparam int PHASE_ITEMS  = 190;

	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [DISP_W-1:0]    reg_val;
		command_t             cmd;
		logic [31:0]          hash;
		logic [15:0]          port;
		logic [11:0]          idx;
		bit                   typed;
		status_t              typed_status;
		logic [15:0]          typed_value;
	} plan_row_t;

	typedef struct {
		status_t     status;
		logic [15:0] value;
	} result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DISP_W-1:0] cfg_data;

	hdtb_req_if req_if();
	hdtb_rsp_if rsp_if();

	hash_displace_table_builder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.request(req_if),
		.response(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] stored_hash [STORE_DEPTH];
	logic [15:0] stored_port [STORE_DEPTH];
	int stored_count;
	logic [LOG2_W-1:0] slot_log2_reg;
	logic [LOG2_W-1:0] bucket_log2_reg;
	logic [DISP_W-1:0] disp_limit_reg;
	logic [DISP_W-1:0] disp_tab [256];
	logic [15:0] bucket_tab [4096];

	result_t pending_results[$];
	plan_row_t plan[$];

	// typed expectation travels with the payload
	bit typed_now;
	status_t typed_status_now;
	logic [15:0] typed_value_now;

	bit idling_on;
	int errors;
	int stall_cycles;
	int n_loads, n_full, n_build_ok, n_build_fail, n_reads;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit run_build();
		int sl, bl, nslots, max_cnt, d;
		logic [31:0] smask, bmask, prod, b;
		int cnt[256];
		int members[$];
		int placed[$];
		bit ok, found;
		sl = (slot_log2_reg > SLOT_MAX) ? SLOT_MAX : slot_log2_reg;
		bl = (bucket_log2_reg > BUCKET_MAX) ? BUCKET_MAX : bucket_log2_reg;
		nslots = 1 << sl;
		smask = nslots - 1;
		bmask = (32'd1 << bl) - 1;
		max_cnt = 0;
		foreach (disp_tab[i]) disp_tab[i] = '0;
		foreach (bucket_tab[i]) bucket_tab[i] = '0;
		foreach (cnt[i]) cnt[i] = 0;
		for (int i = 0; i < stored_count; i++) begin
			cnt[stored_hash[i] & smask]++;
		end
		foreach (cnt[i]) if (cnt[i] > max_cnt) max_cnt = cnt[i];
		// larger slots first, lower index on ties
		for (int c = max_cnt; c > 0; c--) begin
			for (int s = 0; s < nslots; s++) begin
				if (cnt[s] == c) begin
					members.delete();
					for (int i = 0; i < stored_count; i++)
						if ((stored_hash[i] & smask) == s) members.push_back(i);
					found = 0;
					for (d = 1; d < disp_limit_reg && !found; d++) begin
						ok = 1;
						placed.delete();
						foreach (members[m]) begin
							prod = (stored_hash[members[m]] >> HASH_SHIFT) * d;
							b = (prod >> PROD_SHIFT) & bmask;
							if (bucket_tab[b] != 0) begin
								if (bucket_tab[b] == stored_port[members[m]]) continue;
								foreach (placed[k]) bucket_tab[placed[k]] = '0;
								ok = 0;
								break;
							end
							bucket_tab[b] = stored_port[members[m]];
							placed.push_back(b);
						end
						if (ok) begin
							disp_tab[s] = d;
							found = 1;
						end
					end
					if (!found) return 0;
				end
			end
		end
		return 1;
	endfunction

	function automatic result_t table_predict(input command_t c, input logic [31:0] h,
			input logic [15:0] p, input logic [11:0] ix);
		result_t r;
		r.value = '0;
		case (c)
			CMD_LOAD: begin
				if (stored_count >= STORE_DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					stored_hash[stored_count] = h;
					stored_port[stored_count] = p;
					stored_count++;
					r.status = STAT_LOADED;
				end
			end
			CMD_BUILD: r.status = run_build() ? STAT_BUILD_OK : STAT_BUILD_FAIL;
			CMD_READ_DISP: begin
				r.status = STAT_READ;
				if (ix < 256) r.value = disp_tab[ix];
			end
			default: begin
				r.status = STAT_READ;
				r.value = bucket_tab[ix];
			end
		endcase
		return r;
	endfunction

	// request side: predict at acceptance
	always @(posedge clk) begin
		result_t r;
		if (req_if.valid && req_if.ready) begin
			r = table_predict(command_t'(req_if.command), req_if.key_hash, req_if.port,
				req_if.read_index);
			if (typed_now) begin
				r.status = typed_status_now;
				r.value = typed_value_now;
			end
			pending_results.push_back(r);
		end
	end

	// response side: compare against the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (rsp_if.valid && rsp_if.ready) begin
			case (status_t'(rsp_if.status))
				STAT_LOADED: n_loads++;
				STAT_FULL: n_full++;
				STAT_BUILD_OK: n_build_ok++;
				STAT_BUILD_FAIL: n_build_fail++;
				default: n_reads++;
			endcase
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item status %0d value %0h", $time,
					rsp_if.status, rsp_if.read_value);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp_if.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status,
						rsp_if.status);
					errors++;
				end
				if (rsp_if.read_value !== e.value) begin
					$display("%0t: read_value expected %0h actual %0h", $time, e.value,
						rsp_if.read_value);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		rsp_if.ready <= !idling_on || ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("hash_displace_table_builder_unit regression: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_req(input command_t c, input logic [31:0] h, input logic [15:0] p,
			input logic [11:0] ix, input bit typed, input status_t ts, input logic [15:0] tv);
		@(negedge clk);
		while (idling_on && $urandom_range(99) < 20) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.command = c;
		req_if.key_hash = h;
		req_if.port = p;
		req_if.read_index = ix;
		typed_now = typed;
		typed_status_now = ts;
		typed_value_now = tv;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [DISP_W-1:0] rv);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = ri;
		cfg_data = rv;
		case (ri)
			REG_SLOT_LOG2: slot_log2_reg = rv[LOG2_W-1:0];
			REG_BUCKET_LOG2: bucket_log2_reg = rv[LOG2_W-1:0];
			default: disp_limit_reg = rv;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_item(input int load_pm);
		int r, bl;
		logic [15:0] p;
		r = $urandom_range(999);
		bl = (bucket_log2_reg > BUCKET_MAX) ? BUCKET_MAX : bucket_log2_reg;
		p = ($urandom_range(99) < 30) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, 65535));
		if (r < 5)
			send_req(CMD_BUILD, $urandom, p, 12'($urandom), 0, STAT_READ, '0);
		else if (r < 5 + load_pm)
			send_req(CMD_LOAD, $urandom, p, 12'($urandom), 0, STAT_READ, '0);
		else if ($urandom_range(1))
			send_req(CMD_READ_BKT, $urandom, p, 12'($urandom_range(0, (1 << bl) - 1)), 0,
				STAT_READ, '0);
		else
			send_req(CMD_READ_DISP, $urandom, p, ($urandom_range(9) == 0) ?
				12'($urandom_range(256, 4095)) : 12'($urandom_range(0, 255)), 0, STAT_READ, '0);
	endtask

	initial begin
		int ph_slot[6] = '{2, 0, 8, 4, 5, 8};
		int ph_bkt[6] = '{6, 12, 12, 3, 12, 12};
		int ph_lim[6] = '{2047, 40, 2047, 3, 2047, 2047};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SLOT_LOG2;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.command = CMD_LOAD;
		req_if.key_hash = '0;
		req_if.port = '0;
		req_if.read_index = '0;
		rsp_if.ready = 1'b0;
		typed_now = 0;
		typed_status_now = STAT_READ;
		typed_value_now = '0;
		idling_on = 1;
		errors = 0;
		stall_cycles = 0;
		n_loads = 0; n_full = 0; n_build_ok = 0; n_build_fail = 0; n_reads = 0;
		stored_count = 0;
		slot_log2_reg = 4'd8;
		bucket_log2_reg = 4'd12;
		disp_limit_reg = 11'd2047;
		foreach (disp_tab[i]) disp_tab[i] = '0;
		foreach (bucket_tab[i]) bucket_tab[i] = '0;

		// oversized log2 values, limit too small to try any displacement
		plan.push_back('{1, REG_SLOT_LOG2, 11'd15, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{1, REG_BUCKET_LOG2, 11'd15, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{1, REG_DISP_LIMIT, 11'd1, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_READ_DISP, 0, 0, 12'd0, 1, STAT_READ, 16'd0});
		plan.push_back('{0, 0, 0, CMD_READ_BKT, 0, 0, 12'd0, 1, STAT_READ, 16'd0});
		plan.push_back('{0, 0, 0, CMD_READ_BKT, 0, 0, 12'd4095, 1, STAT_READ, 16'd0});
		plan.push_back('{0, 0, 0, CMD_READ_DISP, 0, 0, 12'd4095, 1, STAT_READ, 16'd0});
		plan.push_back('{0, 0, 0, CMD_BUILD, 0, 0, 0, 1, STAT_BUILD_OK, 16'd0});
		plan.push_back('{0, 0, 0, CMD_LOAD, 32'h0, 16'h0001, 0, 1, STAT_LOADED, 16'd0});
		plan.push_back('{0, 0, 0, CMD_LOAD, 32'hffffffff, 16'hffff, 12'hfff, 1,
			STAT_LOADED, 16'd0});
		// port zero is stored as is
		plan.push_back('{0, 0, 0, CMD_LOAD, 32'h00012c05, 16'h0, 0, 1, STAT_LOADED, 16'd0});
		plan.push_back('{0, 0, 0, CMD_BUILD, 0, 0, 0, 1, STAT_BUILD_FAIL, 16'd0});
		plan.push_back('{1, REG_DISP_LIMIT, 11'd2047, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_BUILD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_READ_DISP, 0, 0, 12'd0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_READ_DISP, 0, 0, 12'd255, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_READ_DISP, 0, 0, 12'd5, 0, STAT_READ, 0});
		// one slot, one bucket: distinct ports cannot share it
		plan.push_back('{1, REG_SLOT_LOG2, 11'd0, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{1, REG_BUCKET_LOG2, 11'd0, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{1, REG_DISP_LIMIT, 11'd2, CMD_LOAD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_BUILD, 0, 0, 0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_READ_BKT, 0, 0, 12'd0, 0, STAT_READ, 0});
		plan.push_back('{0, 0, 0, CMD_READ_DISP, 0, 0, 12'd0, 0, STAT_READ, 0});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_drained();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_req(plan[i].cmd, plan[i].hash, plan[i].port, plan[i].idx, plan[i].typed,
					plan[i].typed_status, plan[i].typed_value);
			end
		end

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_reg(REG_SLOT_LOG2, 11'(ph_slot[ph]));
			write_reg(REG_BUCKET_LOG2, 11'(ph_bkt[ph]));
			write_reg(REG_DISP_LIMIT, 11'(ph_lim[ph]));
			// one phase runs with no idling on either side
			idling_on = (ph != 3);
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_item((ph == 5) ? 940 : 880);
			send_req(CMD_BUILD, '0, '0, '0, 0, STAT_READ, '0);
		end

		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d loads, %0d refused full, %0d builds passed, %0d failed",
			n_loads, n_full, n_build_ok, n_build_fail);
		$display("and %0d table reads over six register settings", n_reads);
		if (errors == 0) begin
			$display("hash_displace_table_builder_unit regression: pass");
		end else begin
			$display("hash_displace_table_builder_unit regression: fail");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hdtb_pkg.sv
rtl/hdtb_req_if.sv
rtl/hdtb_rsp_if.sv
rtl/hdtb_ctrl.sv
rtl/hdtb_dp.sv
rtl/hash_displace_table_builder_unit.sv
tb/sv/hash_displace_table_builder_unit_tb.sv
